// ----- rtl/rwqs_pkg.sv -----
// ----------------------------------------------------------------------------
// rwqs_pkg: shared types and constants for the ready/wait queue scheduler
// Default sizes, opcodes and the command/status bundle.
// ----------------------------------------------------------------------------
package rwqs_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_MAX_WAIT    = 10;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic add;        // append the add record
    logic pop_head;   // step 1
    logic clr_run;    // step 1 on an empty ready queue
    logic start_mod;  // load latched pick, begin modulo reduction
    logic mod_step;   // one restoring-subtract step
    logic sleep_mv;   // step 2: move picked entry into wait queue
    logic age_step;   // step 3: age one wait entry
    logic promote;    // step 4
    logic finish;     // raise the result beat
  } rwqs_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic full;
    logic ready_empty;
    logic mod_done;
    logic age_done;
    logic wait_empty;
  } rwqs_sts_t;

endpackage

// ----- rtl/ready_wait_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// ready_wait_queue_scheduler: top level
// Ready FIFO and sorted wait queue of process records.
// ----------------------------------------------------------------------------
// Add: the accepting cycle moves to the FIN state, which registers the result beat.
// Tick: pop, 16-step modulo reduction and sleep move (skipped when nothing goes to
// sleep), one-entry-per-cycle ageing walk over up to 16 wait entries, promotion.
// One item at a time; busy is high until the result beat, next start taken then.
// Synchronous reset empties both queues and clears the running register.
module ready_wait_queue_scheduler
  import rwqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int MAX_WAIT    = DEF_MAX_WAIT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [7:0]  in_proc_id,
  input  logic        in_proc_background,
  input  logic [15:0] in_sleep_pick,
  input  logic [3:0]  in_wait_time,
  output logic        out_strobe,
  output logic        out_add_accepted,
  output logic        out_running_valid,
  output logic [7:0]  out_running_id,
  output logic        out_running_background,
  output logic        out_running_promoted,
  output logic [4:0]  out_ready_count,
  output logic [4:0]  out_wait_count
);

  rwqs_cmd_t cmd;
  rwqs_sts_t sts;

  rwqs_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_operation, .sts, .cmd, .busy
  );

  rwqs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_WAIT(MAX_WAIT)) u_dp (
    .clk, .rst_n, .start, .busy, .in_proc_id, .in_proc_background,
    .in_sleep_pick, .in_wait_time, .cmd, .sts, .out_strobe,
    .out_add_accepted, .out_running_valid, .out_running_id,
    .out_running_background, .out_running_promoted,
    .out_ready_count, .out_wait_count
  );

endmodule

// ----- rtl/rwqs_ctrl.sv -----
// ----------------------------------------------------------------------------
// rwqs_ctrl: command sequencer
// Steps an item through the scheduling phases and drives the datapath.
// ----------------------------------------------------------------------------
module rwqs_ctrl
  import rwqs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_operation,
  input  rwqs_sts_t sts,
  output rwqs_cmd_t cmd,
  output logic      busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_SLP  = 3'd3;
  localparam logic [2:0] S_AGE  = 3'd4;
  localparam logic [2:0] S_PRO  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation == OP_ADD) begin
            cmd.add   = !sts.full;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        cmd.pop_head = !sts.ready_empty;
        cmd.clr_run  = sts.ready_empty;
        state_nxt    = S_MOD;
      end
      S_MOD: begin
        cmd.start_mod = 1'b1;
        state_nxt     = sts.ready_empty ? S_AGE : S_SLP;
      end
      S_SLP: begin
        if (sts.mod_done) begin
          cmd.sleep_mv = 1'b1;
          state_nxt    = S_AGE;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_AGE: begin
        if (sts.age_done) state_nxt = S_PRO;
        else cmd.age_step = 1'b1;
      end
      S_PRO: begin
        cmd.promote = !sts.wait_empty;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- rtl/rwqs_dp.sv -----
// ----------------------------------------------------------------------------
// rwqs_dp: queue datapath
// Ready and wait queues as shift registers, modulo unit, ageing walk.
// ----------------------------------------------------------------------------
module rwqs_dp
  import rwqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int MAX_WAIT    = DEF_MAX_WAIT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  in_proc_id,
  input  logic        in_proc_background,
  input  logic [15:0] in_sleep_pick,
  input  logic [3:0]  in_wait_time,
  input  rwqs_cmd_t   cmd,
  output rwqs_sts_t   sts,
  output logic        out_strobe,
  output logic        out_add_accepted,
  output logic        out_running_valid,
  output logic [7:0]  out_running_id,
  output logic        out_running_background,
  output logic        out_running_promoted,
  output logic [4:0]  out_ready_count,
  output logic [4:0]  out_wait_count
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int WW = $clog2(MAX_WAIT + 1);

  typedef struct packed {
    logic [7:0]    id;
    logic          bg;
    logic          pro;
    logic [WW-1:0] wt;
  } rec_t;

  rec_t          rdy_r [QUEUE_DEPTH];
  rec_t          wq_r  [QUEUE_DEPTH];
  logic [CW-1:0] rlen_r, wlen_r;
  rec_t          run_r;
  logic          run_v_r;
  logic [15:0]   rem_r;
  logic [4:0]    mbit_r;
  logic          mod_done_r;
  logic [CW-1:0] ai_r, kept_r;
  logic [WW-1:0] wt_r;
  logic [15:0]   pick_r;
  logic          acc_r;

  // clamp wait
  logic [WW-1:0] wt_c;
  always_comb begin
    if (in_wait_time == 4'd0) wt_c = WW'(1);
    else if (32'(in_wait_time) > MAX_WAIT) wt_c = WW'(MAX_WAIT);
    else wt_c = WW'(in_wait_time);
  end

  // restoring modulo: one bit per cycle
  logic [31:0] sub_w;
  assign sub_w = {16'd0, rem_r} - (32'(rlen_r) << mbit_r);

  // sleep insert position: after all waits <= new
  logic [CW-1:0] ins_pos;
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++)
      if (CW'(i) < wlen_r && wq_r[i].wt <= wt_r) ins_pos = CW'(i + 1);
  end

  logic [IW-1:0] pick_i;
  assign pick_i = rem_r[IW-1:0];
  logic [IW-1:0] ai_i;
  assign ai_i = ai_r[IW-1:0];
  logic [IW-1:0] kept_i;
  assign kept_i = kept_r[IW-1:0];
  rec_t aged;
  always_comb begin
    aged    = wq_r[ai_i];
    aged.wt = aged.wt - WW'(1);
  end

  // the walk ends once every entry present at its start has been aged
  assign sts.full        = (32'(rlen_r) + 32'(wlen_r)) >= QUEUE_DEPTH;
  assign sts.ready_empty = (rlen_r == '0);
  assign sts.mod_done    = mod_done_r;
  assign sts.age_done    = (ai_r >= wlen_r);
  assign sts.wait_empty  = (wlen_r == '0);

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      pick_r <= in_sleep_pick;
      wt_r   <= wt_c;
    end
    if (cmd.add) begin
      rdy_r[rlen_r[IW-1:0]] <= '{id: in_proc_id, bg: in_proc_background, pro: 1'b0, wt: '0};
    end
    if (cmd.pop_head) begin
      run_r <= rdy_r[0];
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) rdy_r[i] <= rdy_r[i + 1];
    end
    if (cmd.start_mod) begin
      rem_r      <= pick_r;
      mbit_r     <= 5'd15;
      mod_done_r <= 1'b0;
    end
    if (cmd.mod_step) begin
      if (!sub_w[31]) rem_r <= sub_w[15:0];
      if (mbit_r == 5'd0) mod_done_r <= 1'b1;
      else mbit_r <= mbit_r - 5'd1;
    end
    if (cmd.sleep_mv) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        if (IW'(i) >= pick_i) rdy_r[i] <= rdy_r[i + 1];
      for (int i = 1; i < QUEUE_DEPTH; i++)
        if (CW'(i) > ins_pos) wq_r[i] <= wq_r[i - 1];
      wq_r[ins_pos[IW-1:0]] <= '{id: rdy_r[pick_i].id, bg: rdy_r[pick_i].bg,
                                 pro: rdy_r[pick_i].pro, wt: wt_r};
    end
    if (cmd.age_step) begin
      if (aged.wt == '0) rdy_r[rlen_r[IW-1:0]] <= aged;
      else wq_r[kept_i] <= aged;
    end
    if (cmd.promote) begin
      rdy_r[rlen_r[IW-1:0]] <= '{id: wq_r[0].id, bg: wq_r[0].bg, pro: 1'b1, wt: wq_r[0].wt};
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) wq_r[i] <= wq_r[i + 1];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rlen_r     <= '0;
      wlen_r     <= '0;
      run_v_r    <= 1'b0;
      ai_r       <= '0;
      kept_r     <= '0;
      acc_r      <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.finish;
      if (start && !busy) begin
        acc_r  <= cmd.add;
        ai_r   <= '0;
        kept_r <= '0;
      end
      if (cmd.add) begin
        rlen_r <= rlen_r + CW'(1);
      end
      if (cmd.pop_head) begin
        rlen_r  <= rlen_r - CW'(1);
        run_v_r <= 1'b1;
      end
      // a tick on an empty ready queue clears the running register
      if (cmd.clr_run) run_v_r <= 1'b0;
      if (cmd.sleep_mv) begin
        rlen_r <= rlen_r - CW'(1);
        wlen_r <= wlen_r + CW'(1);
      end
      if (cmd.age_step) begin
        ai_r <= ai_r + CW'(1);
        if (aged.wt == '0) rlen_r <= rlen_r + CW'(1);
        else kept_r <= kept_r + CW'(1);
        if (ai_r + CW'(1) == wlen_r) wlen_r <= (aged.wt == '0) ? kept_r : kept_r + CW'(1);
      end
      if (cmd.promote) begin
        rlen_r <= rlen_r + CW'(1);
        wlen_r <= wlen_r - CW'(1);
      end
    end
  end

  assign out_add_accepted       = acc_r;
  assign out_running_valid      = run_v_r;
  assign out_running_id         = run_v_r ? run_r.id : 8'd0;
  assign out_running_background = run_v_r & run_r.bg;
  assign out_running_promoted   = run_v_r & run_r.pro;
  assign out_ready_count        = 5'(rlen_r);
  assign out_wait_count         = 5'(wlen_r);

endmodule

// ----- rtl/rwqs_checker.sv -----
// ----------------------------------------------------------------------------
// rwqs_props: port-level checks
// Observes the top level's ports only.
// ----------------------------------------------------------------------------
module rwqs_props (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_add_accepted,
  input logic       out_running_valid,
  input logic [7:0] out_running_id,
  input logic [4:0] out_ready_count,
  input logic [4:0] out_wait_count
);

  // accepted item makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("not busy after start");

  // a beat ends the busy period
  a_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("busy during result beat");

  // shared store never overfills
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (6'(out_ready_count) + 6'(out_wait_count) <= 6'd16))
    else $error("store overfilled");

  // idle running register reads zero
  a_idz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_running_valid) |-> (out_running_id == 8'd0))
    else $error("stale running id");

  // an accepted add leaves at least one ready entry
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_add_accepted) |-> (out_ready_count != 5'd0))
    else $error("accepted add with empty ready queue");

endmodule

bind ready_wait_queue_scheduler rwqs_props u_chk (
  .clk, .rst_n, .start, .busy, .out_strobe, .out_add_accepted,
  .out_running_valid, .out_running_id, .out_ready_count, .out_wait_count
);
